@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the process queue checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define KOPQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("kopq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define KOPQ_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("kopq assertion failed");

`endif

@@ sv/kopq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kopq_pkg
// types, request and status codes shared by the process queue modules
// ----------------------------------------------------------------------------
package kopq_pkg;

	// request codes, code 7 has no meaning
	typedef enum logic [2:0] {
		REQ_APPEND    = 3'd0,
		REQ_RM_ID     = 3'd1,
		REQ_FIND_ID   = 3'd2,
		REQ_READ_POS  = 3'd3,
		REQ_RM_HANDLE = 3'd4,
		REQ_CLEAR     = 3'd5,
		REQ_RM_FIRST  = 3'd6
	} req_code_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// request payload
	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] proc_id;
		logic [15:0] proc_handle;
		logic [5:0]  position;
	} kopq_req_t;

	// result payload
	typedef struct packed {
		status_t     status;
		logic [15:0] out_id;
		logic [15:0] out_handle;
		logic [6:0]  entry_count;
	} kopq_rsp_t;

	// one stored queue entry
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] handle;
	} entry_t;

	// source of the result entry
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_REQ  = 2'd1,
		SRC_RD   = 2'd2
	} res_src_t;

	// walk pointer operations
	typedef enum logic [2:0] {
		PTR_HOLD     = 3'd0,
		PTR_ZERO     = 3'd1,
		PTR_POS      = 3'd2,
		PTR_NEXT_HIT = 3'd3,
		PTR_INC      = 3'd4
	} ptr_op_t;

	// controller to datapath commands
	typedef struct packed {
		logic     latch_req;
		logic     res_load;
		status_t  res_status;
		res_src_t res_src;
		logic     append_wr;
		logic     cnt_clear;
		logic     cnt_dec;
		ptr_op_t  ptr_op;
		logic     scan_issue;
		logic     hit_load;
		logic     hit_inc;
		logic     shift_wr;
		logic     out_load;
	} kopq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] req_type;
		logic       full;
		logic       pos_ok;
		logic       hit;
		logic       more;
		logic       tail;
		logic       shift_last;
	} kopq_sts_t;

endpackage

@@ sv/kopq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kopq_ctrl
// sequencer for the process queue: dispatch, scan, shift, position read and result transfer
// ----------------------------------------------------------------------------
module kopq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  kopq_pkg::kopq_sts_t sts,
	output kopq_pkg::kopq_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE        = 8'b0000_0001,
		S_DISPATCH    = 8'b0000_0010,
		S_SCAN        = 8'b0000_0100,
		S_SHIFT_PRIME = 8'b0000_1000,
		S_SHIFT       = 8'b0001_0000,
		S_POS_READ    = 8'b0010_0000,
		S_POS_CAPTURE = 8'b0100_0000,
		S_FINISH      = 8'b1000_0000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        rsp_valid_q;
	logic        out_free;
	logic        is_find;

	// output register can take a new result
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign is_find   = (sts.req_type == kopq_pkg::REQ_FIND_ID);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd.latch_req  = 1'b0;
		cmd.res_load   = 1'b0;
		cmd.res_status = kopq_pkg::ST_MISS;
		cmd.res_src    = kopq_pkg::SRC_ZERO;
		cmd.append_wr  = 1'b0;
		cmd.cnt_clear  = 1'b0;
		cmd.cnt_dec    = 1'b0;
		cmd.ptr_op     = kopq_pkg::PTR_HOLD;
		cmd.scan_issue = 1'b0;
		cmd.hit_load   = 1'b0;
		cmd.hit_inc    = 1'b0;
		cmd.shift_wr   = 1'b0;
		cmd.out_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.req_type)
					kopq_pkg::REQ_APPEND: begin
						cmd.res_load = 1'b1;
						if (sts.full) begin
							cmd.res_status = kopq_pkg::ST_FULL;
						end else begin
							cmd.append_wr  = 1'b1;
							cmd.res_status = kopq_pkg::ST_DONE;
							cmd.res_src    = kopq_pkg::SRC_REQ;
						end
						state_d = S_FINISH;
					end
					kopq_pkg::REQ_RM_ID, kopq_pkg::REQ_FIND_ID,
					kopq_pkg::REQ_RM_HANDLE, kopq_pkg::REQ_RM_FIRST: begin
						cmd.ptr_op = kopq_pkg::PTR_ZERO;
						state_d    = S_SCAN;
					end
					kopq_pkg::REQ_READ_POS: begin
						if (sts.pos_ok) begin
							cmd.ptr_op = kopq_pkg::PTR_POS;
							state_d    = S_POS_READ;
						end else begin
							cmd.res_load = 1'b1;
							state_d      = S_FINISH;
						end
					end
					kopq_pkg::REQ_CLEAR: begin
						cmd.cnt_clear  = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = kopq_pkg::ST_DONE;
						state_d        = S_FINISH;
					end
					default: begin
						cmd.res_load = 1'b1;
						state_d      = S_FINISH;
					end
				endcase
			end
			// one read issued and one compare made per cycle
			S_SCAN: begin
				if (sts.hit) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = kopq_pkg::ST_DONE;
					cmd.res_src    = kopq_pkg::SRC_RD;
					if (is_find) begin
						state_d = S_FINISH;
					end else if (sts.tail) begin
						cmd.hit_load = 1'b1;
						cmd.ptr_op   = kopq_pkg::PTR_NEXT_HIT;
						state_d      = S_SHIFT_PRIME;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_FINISH;
					end
				end else if (!sts.more) begin
					cmd.res_load = 1'b1;
					state_d      = S_FINISH;
				end else begin
					cmd.scan_issue = 1'b1;
					cmd.ptr_op     = kopq_pkg::PTR_INC;
				end
			end
			S_SHIFT_PRIME: begin
				cmd.ptr_op = kopq_pkg::PTR_INC;
				state_d    = S_SHIFT;
			end
			// close the gap, one entry moved per cycle
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				cmd.hit_inc  = 1'b1;
				if (sts.shift_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.ptr_op = kopq_pkg::PTR_INC;
				end
			end
			S_POS_READ: begin
				state_d = S_POS_CAPTURE;
			end
			S_POS_CAPTURE: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = kopq_pkg::ST_DONE;
				cmd.res_src    = kopq_pkg::SRC_RD;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/kopq_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kopq_dpath
// entry memory, count, walk pointers, compare and result registers
// ----------------------------------------------------------------------------
module kopq_dpath #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kopq_pkg::kopq_req_t req,
	input  kopq_pkg::kopq_cmd_t cmd,
	output kopq_pkg::kopq_sts_t sts,
	output kopq_pkg::kopq_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	kopq_pkg::entry_t    mem [DEPTH];
	kopq_pkg::kopq_req_t req_q;
	kopq_pkg::entry_t    rd_q;
	kopq_pkg::entry_t    res_entry_q;
	kopq_pkg::status_t   res_status_q;
	kopq_pkg::kopq_rsp_t rsp_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       rd_idx_q;
	logic [CW-1:0]       hit_idx_q;
	logic [CW-1:0]       next_idx;
	logic                rd_v_q;
	logic                key_match;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	kopq_pkg::entry_t    mem_wdata;

	assign next_idx = rd_idx_q + CW'(1);

	// key compare on the entry read last cycle
	always_comb begin
		case (req_q.req_type)
			kopq_pkg::REQ_RM_HANDLE: key_match = (rd_q.handle == req_q.proc_handle);
			kopq_pkg::REQ_RM_FIRST:  key_match = 1'b1;
			default:                 key_match = (rd_q.id == req_q.proc_id);
		endcase
	end

	// status toward the controller
	always_comb begin
		sts.req_type   = req_q.req_type;
		sts.full       = (count_q == CW'(DEPTH));
		sts.pos_ok     = (32'(req_q.position) < 32'(count_q));
		sts.hit        = rd_v_q && key_match;
		sts.more       = (ptr_q < count_q);
		sts.tail       = (next_idx < count_q);
		sts.shift_last = (ptr_q >= count_q);
	end

	// memory write port: append at tail or move one entry down
	always_comb begin
		mem_we    = cmd.append_wr || cmd.shift_wr;
		mem_waddr = hit_idx_q[AW-1:0];
		mem_wdata = rd_q;
		if (cmd.append_wr) begin
			mem_waddr = count_q[AW-1:0];
			mem_wdata = '{id: req_q.proc_id, handle: req_q.proc_handle};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// registered read at the walk pointer
	always_ff @(posedge clk) begin
		rd_q <= mem[ptr_q[AW-1:0]];
	end

	// request latch and payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		if (cmd.scan_issue) begin
			rd_idx_q <= ptr_q;
		end
		if (cmd.hit_load) begin
			hit_idx_q <= rd_idx_q;
		end else if (cmd.hit_inc) begin
			hit_idx_q <= hit_idx_q + CW'(1);
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_src)
				kopq_pkg::SRC_REQ: res_entry_q <= '{id: req_q.proc_id, handle: req_q.proc_handle};
				kopq_pkg::SRC_RD:  res_entry_q <= rd_q;
				default:           res_entry_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.out_id      <= res_entry_q.id;
			rsp_q.out_handle  <= res_entry_q.handle;
			rsp_q.entry_count <= 7'(32'(count_q));
		end
	end

	// entry count, walk pointer and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			rd_v_q  <= 1'b0;
		end else begin
			rd_v_q <= cmd.scan_issue && sts.more;
			if (cmd.cnt_clear) begin
				count_q <= '0;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.append_wr) begin
				count_q <= count_q + CW'(1);
			end
			case (cmd.ptr_op)
				kopq_pkg::PTR_ZERO:     ptr_q <= '0;
				kopq_pkg::PTR_POS:      ptr_q <= CW'(req_q.position);
				kopq_pkg::PTR_NEXT_HIT: ptr_q <= next_idx;
				kopq_pkg::PTR_INC:      ptr_q <= ptr_q + CW'(1);
				default:                ptr_q <= ptr_q;
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/keyed_ordered_process_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_ordered_process_queue_core
// ordered process queue with append, keyed find and order-keeping removal
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | kopq_req_t
//  rsp     | out       | rsp_valid/rsp_stall | kopq_rsp_t
//
//  one request at a time. a search walks the entries from the head and
//  stops at the first hit or at the end of the queue; a removal ahead of
//  the last entry then moves each later entry down to close the gap, both
//  walking the entry memory (one read and one write port) one entry per
//  cycle. the entry count clears on reset, the memory has no reset.
//  a stalled result sits in the output register while the next request is
//  taken; the sequencer waits for it only when its own result is ready.
module keyed_ordered_process_queue_core #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  kopq_pkg::kopq_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output kopq_pkg::kopq_rsp_t rsp
);

	kopq_pkg::kopq_cmd_t cmd;
	kopq_pkg::kopq_sts_t sts;

	// sequencer
	kopq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and compare
	kopq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ sv/kopq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kopq_port_checks
// port-level checks on the process queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kopq_port_checks #(
	parameter int DEPTH = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input kopq_pkg::kopq_req_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input kopq_pkg::kopq_rsp_t rsp
);

	logic req_xfer;
	logic rsp_miss;
	logic rsp_full;

	assign req_xfer = req_valid && !req_stall;
	assign rsp_miss = rsp_valid && (rsp.status == kopq_pkg::ST_MISS);
	assign rsp_full = rsp_valid && (rsp.status == kopq_pkg::ST_FULL);

	// a stalled result holds
	`KOPQ_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one request in flight: the transfer closes the input
	`KOPQ_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_xfer, req_stall)

	// a miss carries no entry
	`KOPQ_ASSERT_IMP(a_miss_zero, clk, arst_n, rsp_miss, rsp.out_id == '0 && rsp.out_handle == '0)

	// full only with the queue at capacity
	`KOPQ_ASSERT_IMP(a_full_count, clk, arst_n, rsp_full, rsp.entry_count == 7'(DEPTH))

	// a waiting request holds
	`KOPQ_ASSERT_NXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req))

endmodule

bind keyed_ordered_process_queue_core kopq_port_checks #(
	.DEPTH (DEPTH)
) u_kopq_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
